// File: rtl/core/asbd_pkg.sv
// shared types, codes and defaults for the adpcm speech block decoder
`default_nettype none

package asbd_pkg;

    localparam int MAX_BLOCKS_DEF        = 4096;
    localparam int FIXED_BLOCK_BYTES_DEF = 128;

    localparam int CFG_IDX_W = 3;
    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_PARSE_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_NIBBLE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_FIRST      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRESH_PRED      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HONOR_RATE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_CLEARS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_IN_BYTES  = 3'd6;

    typedef enum logic [2:0] {
        KIND_SAMPLE  = 3'd0,
        KIND_SILENCE = 3'd1,
        KIND_BLOCK   = 3'd2,
        KIND_END     = 3'd3,
        KIND_REPEAT  = 3'd4,
        KIND_UNKNOWN = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        STAGE_OPCODE,
        STAGE_COUNT,
        STAGE_DATA
    } stage_t;

    typedef struct packed {
        logic parse_mode;
        logic low_nibble_first;
        logic drop_first_nibble;
        logic fresh_predictor_per_block;
        logic honor_rate_markers;
        logic silence_clears_predictor;
        logic count_in_bytes;
    } cfg_t;

    typedef struct packed {
        logic        is_data;
        logic        clear;
        kind_t       kind;
        logic [14:0] run;
        logic [5:0]  div;
        logic        from_marker;
        logic [3:0]  nib0;
        logic [3:0]  nib1;
        logic        two;
    } cmd_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] pcm;
        logic [14:0] run;
        logic [5:0]  div;
        logic        from_marker;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/asbd_front.sv
// opcode parser: accepts rom words and issues decode commands
`default_nettype none

module asbd_front
    import asbd_pkg::*;
#(
    parameter int MAX_BLOCKS        = MAX_BLOCKS_DEF,
    parameter int FIXED_BLOCK_BYTES = FIXED_BLOCK_BYTES_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rom_byte,
    input  wire logic       phrase_begin,
    output logic            cmd_valid,
    output cmd_t            cmd,
    input  wire logic       cmd_ready
);

    localparam int BLK_W = $clog2(MAX_BLOCKS + 1);

    stage_t           stage_reg, stage_next;
    logic [8:0]       bytes_left_reg, bytes_left_next;
    logic             seen_reg, seen_next;
    logic             dropped_reg, dropped_next;
    logic [BLK_W-1:0] blocks_reg, blocks_next;
    logic             finished_reg, finished_next;

    stage_t           stage_eff;
    logic [8:0]       bytes_left_eff;
    logic             seen_eff;
    logic             dropped_eff;
    logic [BLK_W-1:0] blocks_eff;
    logic             finished_eff;

    logic             accept;
    logic             fixed;
    logic [1:0]       top;
    logic [3:0]       nib_a;
    logic [3:0]       nib_b;
    logic [8:0]       count_val;
    logic [8:0]       left_dec;

    assign in_ready = cmd_ready;
    assign accept   = in_valid && cmd_ready;
    assign top      = rom_byte[7:6];
    assign nib_a    = cfg.low_nibble_first ? rom_byte[3:0] : rom_byte[7:4];
    assign nib_b    = cfg.low_nibble_first ? rom_byte[7:4] : rom_byte[3:0];

    always_comb
    begin
        // a phrase start clears decode state before the word is parsed
        stage_eff      = phrase_begin ? STAGE_OPCODE : stage_reg;
        bytes_left_eff = phrase_begin ? 9'd0 : bytes_left_reg;
        seen_eff       = phrase_begin ? 1'b0 : seen_reg;
        dropped_eff    = phrase_begin ? 1'b0 : dropped_reg;
        blocks_eff     = phrase_begin ? '0 : blocks_reg;
        finished_eff   = phrase_begin ? 1'b0 : finished_reg;

        fixed     = cfg.parse_mode ? (top == 2'b01) : rom_byte[6];
        count_val = cfg.count_in_bytes ? ({1'b0, rom_byte} + 9'd1)
                                       : (({1'b0, rom_byte} + 9'd1) >> 1);
        left_dec  = bytes_left_eff - 9'd1;

        stage_next      = stage_eff;
        bytes_left_next = bytes_left_eff;
        seen_next       = seen_eff;
        dropped_next    = dropped_eff;
        blocks_next     = blocks_eff;
        finished_next   = finished_eff;

        cmd_valid       = 1'b0;
        cmd.is_data     = 1'b0;
        cmd.clear       = phrase_begin;
        cmd.kind        = KIND_END;
        cmd.run         = '0;
        cmd.div         = '0;
        cmd.from_marker = 1'b0;
        cmd.nib0        = nib_a;
        cmd.nib1        = nib_b;
        cmd.two         = 1'b1;

        if (!finished_eff)
        begin
            case (stage_eff)
                STAGE_OPCODE:
                begin
                    cmd_valid = 1'b1;
                    if (blocks_eff >= BLK_W'(MAX_BLOCKS)
                        || (rom_byte == 8'd0 && (!cfg.parse_mode || seen_eff)))
                    begin
                        finished_next = 1'b1;
                        cmd.kind      = KIND_END;
                    end
                    else
                    begin
                        if (rom_byte != 8'd0)
                            seen_next = 1'b1;
                        blocks_next = blocks_eff + BLK_W'(1);
                        if (fixed || top == 2'b10)
                        begin
                            cmd.clear       = phrase_begin || cfg.fresh_predictor_per_block;
                            cmd.kind        = KIND_BLOCK;
                            cmd.div         = cfg.honor_rate_markers ? rom_byte[5:0] : 6'd0;
                            cmd.from_marker = cfg.honor_rate_markers;
                            if (fixed)
                            begin
                                bytes_left_next = 9'(FIXED_BLOCK_BYTES);
                                stage_next      = STAGE_DATA;
                            end
                            else
                            begin
                                stage_next = STAGE_COUNT;
                            end
                        end
                        else if (top == 2'b00)
                        begin
                            cmd.clear = phrase_begin || cfg.silence_clears_predictor;
                            cmd.kind  = KIND_SILENCE;
                            cmd.run   = {7'({1'b0, rom_byte[5:0]} + 7'd1), 8'd0};
                        end
                        else
                        begin
                            cmd.kind = KIND_REPEAT;
                            cmd.run  = 15'({1'b0, rom_byte[2:0]} + 4'd1);
                        end
                    end
                end
                STAGE_COUNT:
                begin
                    bytes_left_next = count_val;
                    stage_next      = (count_val != 9'd0) ? STAGE_DATA : STAGE_OPCODE;
                end
                STAGE_DATA:
                begin
                    cmd_valid   = 1'b1;
                    cmd.is_data = 1'b1;
                    if (cfg.drop_first_nibble && !dropped_eff)
                    begin
                        dropped_next = 1'b1;
                        cmd.nib0     = nib_b;
                        cmd.two      = 1'b0;
                    end
                    if (bytes_left_eff != 9'd0)
                        bytes_left_next = left_dec;
                    if (bytes_left_eff == 9'd0 || left_dec == 9'd0)
                        stage_next = STAGE_OPCODE;
                end
                default:
                begin
                    stage_next = STAGE_OPCODE;
                end
            endcase
        end

        cmd_valid = cmd_valid && accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg      <= STAGE_OPCODE;
            bytes_left_reg <= '0;
            seen_reg       <= 1'b0;
            dropped_reg    <= 1'b0;
            blocks_reg     <= '0;
            finished_reg   <= 1'b0;
        end
        else if (accept)
        begin
            stage_reg      <= stage_next;
            bytes_left_reg <= bytes_left_next;
            seen_reg       <= seen_next;
            dropped_reg    <= dropped_next;
            blocks_reg     <= blocks_next;
            finished_reg   <= finished_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/asbd_cmd_fifo.sv
// short command queue between parser and decoder
`default_nettype none

module asbd_cmd_fifo
    import asbd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      not_full,
    input  wire logic pop,
    output logic      not_empty,
    output cmd_t      head
);

    cmd_t                 mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_CNT_W-1:0] count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign not_full  = count_reg != CMD_CNT_W'(CMD_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/asbd_back.sv
// adpcm decoder: one nibble a cycle into the output register while that register is free
`default_nettype none

module asbd_back
    import asbd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    input  wire cmd_t q_cmd,
    output logic      q_pop,
    output logic      out_valid,
    input  wire logic out_ready,
    output result_t   res
);

    localparam logic [7:0] STEP_MAG [16][8] = '{
        '{8'd0, 8'd0,  8'd1,  8'd2,  8'd3,  8'd5,   8'd7,   8'd10},
        '{8'd0, 8'd1,  8'd2,  8'd3,  8'd4,  8'd6,   8'd8,   8'd13},
        '{8'd0, 8'd1,  8'd2,  8'd4,  8'd5,  8'd7,   8'd10,  8'd15},
        '{8'd0, 8'd1,  8'd3,  8'd4,  8'd6,  8'd9,   8'd13,  8'd19},
        '{8'd0, 8'd2,  8'd3,  8'd5,  8'd8,  8'd11,  8'd15,  8'd23},
        '{8'd0, 8'd2,  8'd4,  8'd7,  8'd10, 8'd14,  8'd19,  8'd29},
        '{8'd0, 8'd3,  8'd5,  8'd8,  8'd12, 8'd16,  8'd22,  8'd33},
        '{8'd1, 8'd4,  8'd7,  8'd10, 8'd15, 8'd20,  8'd29,  8'd43},
        '{8'd1, 8'd4,  8'd8,  8'd13, 8'd18, 8'd25,  8'd35,  8'd53},
        '{8'd1, 8'd6,  8'd10, 8'd16, 8'd22, 8'd31,  8'd43,  8'd64},
        '{8'd2, 8'd7,  8'd12, 8'd19, 8'd27, 8'd37,  8'd51,  8'd76},
        '{8'd2, 8'd9,  8'd16, 8'd24, 8'd34, 8'd46,  8'd64,  8'd96},
        '{8'd3, 8'd11, 8'd19, 8'd29, 8'd41, 8'd57,  8'd79,  8'd117},
        '{8'd4, 8'd13, 8'd24, 8'd36, 8'd50, 8'd69,  8'd96,  8'd143},
        '{8'd4, 8'd16, 8'd29, 8'd44, 8'd62, 8'd85,  8'd118, 8'd175},
        '{8'd6, 8'd20, 8'd36, 8'd54, 8'd76, 8'd104, 8'd144, 8'd214}
    };

    localparam logic signed [2:0] INDEX_MOVE [8] = '{
        -3'sd1, -3'sd1, 3'sd0, 3'sd0, 3'sd1, 3'sd2, 3'sd2, 3'sd3
    };

    logic [31:0] pred_reg, pred_next;
    logic [3:0]  step_reg, step_next;
    logic        phase_reg, phase_next;
    logic [3:0]  pend_nib_reg, pend_nib_next;
    logic        out_valid_reg, out_valid_next;
    result_t     res_reg, res_next;

    logic        slot_free;
    logic [3:0]  nib_sel;
    logic [7:0]  mag;
    logic [31:0] delta;
    logic [31:0] dec_pred;
    logic [5:0]  step_sum;
    logic [3:0]  dec_step;
    logic [15:0] dec_pcm;

    assign slot_free = !out_valid_reg || out_ready;
    assign q_pop     = slot_free && !phase_reg && q_valid;
    assign nib_sel   = phase_reg ? pend_nib_reg : q_cmd.nib0;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        mag      = STEP_MAG[step_reg][nib_sel[2:0]];
        delta    = nib_sel[3] ? (32'd0 - {24'd0, mag}) : {24'd0, mag};
        dec_pred = pred_reg + delta;
        step_sum = {2'b00, step_reg} + {{3{INDEX_MOVE[nib_sel[2:0]][2]}},
                                        INDEX_MOVE[nib_sel[2:0]]};
        if (step_sum[5])
            dec_step = 4'd0;
        else if (step_sum[4])
            dec_step = 4'd15;
        else
            dec_step = step_sum[3:0];
        // saturate predictor times 128 to 16 bits
        if (!dec_pred[31] && dec_pred[30:8] != '0)
            dec_pcm = 16'h7fff;
        else if (dec_pred[31] && dec_pred[30:8] != '1)
            dec_pcm = 16'h8000;
        else
            dec_pcm = {dec_pred[8:0], 7'd0};
    end

    always_comb
    begin
        pred_next      = pred_reg;
        step_next      = step_reg;
        phase_next     = phase_reg;
        pend_nib_next  = pend_nib_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_next       = res_reg;

        if (slot_free && phase_reg)
        begin
            pred_next            = dec_pred;
            step_next            = dec_step;
            phase_next           = 1'b0;
            out_valid_next       = 1'b1;
            res_next.kind        = KIND_SAMPLE;
            res_next.pcm         = dec_pcm;
            res_next.run         = '0;
            res_next.div         = '0;
            res_next.from_marker = 1'b0;
            res_next.last        = 1'b1;
        end
        else if (q_pop)
        begin
            out_valid_next = 1'b1;
            if (q_cmd.is_data)
            begin
                pred_next            = dec_pred;
                step_next            = dec_step;
                phase_next           = q_cmd.two;
                pend_nib_next        = q_cmd.nib1;
                res_next.kind        = KIND_SAMPLE;
                res_next.pcm         = dec_pcm;
                res_next.run         = '0;
                res_next.div         = '0;
                res_next.from_marker = 1'b0;
                res_next.last        = !q_cmd.two;
            end
            else
            begin
                if (q_cmd.clear)
                begin
                    pred_next = '0;
                    step_next = '0;
                end
                res_next.kind        = q_cmd.kind;
                res_next.pcm         = '0;
                res_next.run         = q_cmd.run;
                res_next.div         = q_cmd.div;
                res_next.from_marker = q_cmd.from_marker;
                res_next.last        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg      <= '0;
            step_reg      <= '0;
            phase_reg     <= 1'b0;
            pend_nib_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pred_reg      <= pred_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            pend_nib_reg  <= pend_nib_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/adpcm_speech_block_decoder.sv
// top level of the adpcm speech block decoder: config registers and datapath wiring
// path: a word's first result passes the command queue, then the output register
// throughput: one opcode word per cycle unless stalled; the two nibbles of a data
// word take turns in the single decoder; predictor and step index move once per cycle
// reset: asynchronous, clears parser, queue, predictor, output valid flag and config
`default_nettype none

module adpcm_speech_block_decoder
    import asbd_pkg::*;
#(
    parameter int MAX_BLOCKS        = MAX_BLOCKS_DEF,
    parameter int FIXED_BLOCK_BYTES = FIXED_BLOCK_BYTES_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic                 cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           rom_byte,
    input  wire logic                 phrase_begin,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [2:0]                kind,
    output logic signed [15:0]        pcm_sample,
    output logic [14:0]               run_length,
    output logic [5:0]                rate_divider,
    output logic                      rate_from_marker,
    output logic                      last_of_item
);

    cfg_t    cfg_reg;
    logic    cmd_valid;
    cmd_t    cmd;
    logic    fifo_not_full;
    logic    fifo_not_empty;
    logic    fifo_pop;
    cmd_t    fifo_head;
    result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PARSE_MODE:     cfg_reg.parse_mode                <= cfg_data;
                CFG_LOW_NIBBLE:     cfg_reg.low_nibble_first          <= cfg_data;
                CFG_DROP_FIRST:     cfg_reg.drop_first_nibble         <= cfg_data;
                CFG_FRESH_PRED:     cfg_reg.fresh_predictor_per_block <= cfg_data;
                CFG_HONOR_RATE:     cfg_reg.honor_rate_markers        <= cfg_data;
                CFG_SILENCE_CLEARS: cfg_reg.silence_clears_predictor  <= cfg_data;
                CFG_COUNT_IN_BYTES: cfg_reg.count_in_bytes            <= cfg_data;
                default:            cfg_reg                           <= cfg_reg;
            endcase
        end
    end

    asbd_front #(
        .MAX_BLOCKS        (MAX_BLOCKS),
        .FIXED_BLOCK_BYTES (FIXED_BLOCK_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rom_byte     (rom_byte),
        .phrase_begin (phrase_begin),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_ready    (fifo_not_full)
    );

    asbd_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_valid),
        .push_cmd  (cmd),
        .not_full  (fifo_not_full),
        .pop       (fifo_pop),
        .not_empty (fifo_not_empty),
        .head      (fifo_head)
    );

    asbd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (fifo_not_empty),
        .q_cmd     (fifo_head),
        .q_pop     (fifo_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign kind             = res.kind;
    assign pcm_sample       = res.pcm;
    assign run_length       = res.run;
    assign rate_divider     = res.div;
    assign rate_from_marker = res.from_marker;
    assign last_of_item     = res.last;

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// self-checking testbench for the adpcm speech block decoder: directed and random phrases
module testbench
    import asbd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GUARD_BLOCKS  = MAX_BLOCKS_DEF;
    localparam int FIXED_BYTES   = FIXED_BLOCK_BYTES_DEF;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRINT_LIMIT   = 40;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = CFG_PARSE_MODE;
    logic                 cfg_data     = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_ready;
    logic [7:0]           rom_byte     = 8'h00;
    logic                 phrase_begin = 1'b0;
    logic                 out_valid;
    logic                 out_ready    = 1'b0;
    logic [2:0]           kind;
    logic signed [15:0]   pcm_sample;
    logic [14:0]          run_length;
    logic [5:0]           rate_divider;
    logic                 rate_from_marker;
    logic                 last_of_item;

    // decoder model state
    cfg_t        cfg_model    = '0;
    stage_t      parse_stage  = STAGE_OPCODE;
    int          bytes_left   = 0;
    logic [3:0]  step_idx     = 4'd0;
    logic [31:0] pred         = 32'd0;
    logic        seen_nonzero = 1'b0;
    logic        nib_dropped  = 1'b0;
    int          blocks_done  = 0;
    logic        phrase_over  = 1'b0;

    result_t due_results [$];

    int  mismatches   = 0;
    int  words_in     = 0;
    int  live_words   = 0;
    int  results_seen = 0;
    int  phrases_sent = 0;
    int  cycle_count  = 0;
    int  stall_left   = 0;
    logic calm        = 1'b0;

    adpcm_speech_block_decoder u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .rom_byte         (rom_byte),
        .phrase_begin     (phrase_begin),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind),
        .pcm_sample       (pcm_sample),
        .run_length       (run_length),
        .rate_divider     (rate_divider),
        .rate_from_marker (rate_from_marker),
        .last_of_item     (last_of_item)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, due_results.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_LIMIT)
            $display("MISMATCH @%0t: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic result_t make_result(input kind_t k, input logic [15:0] pcm,
                                            input logic [14:0] run, input logic [5:0] div,
                                            input logic mark);
        result_t r;
        r.kind        = k;
        r.pcm         = pcm;
        r.run         = run;
        r.div         = div;
        r.from_marker = mark;
        r.last        = 1'b0;
        return r;
    endfunction

    // one adpcm code: step from the table, index move, saturated sample
    function automatic logic [15:0] decode_nibble(input logic [3:0] code);
        logic [63:0] row;
        int          mag;
        int          nxt;
        longint      scaled;
        case (step_idx)
            4'd0:  row = {8'd10,  8'd7,   8'd5,   8'd3,  8'd2,  8'd1,  8'd0,  8'd0};
            4'd1:  row = {8'd13,  8'd8,   8'd6,   8'd4,  8'd3,  8'd2,  8'd1,  8'd0};
            4'd2:  row = {8'd15,  8'd10,  8'd7,   8'd5,  8'd4,  8'd2,  8'd1,  8'd0};
            4'd3:  row = {8'd19,  8'd13,  8'd9,   8'd6,  8'd4,  8'd3,  8'd1,  8'd0};
            4'd4:  row = {8'd23,  8'd15,  8'd11,  8'd8,  8'd5,  8'd3,  8'd2,  8'd0};
            4'd5:  row = {8'd29,  8'd19,  8'd14,  8'd10, 8'd7,  8'd4,  8'd2,  8'd0};
            4'd6:  row = {8'd33,  8'd22,  8'd16,  8'd12, 8'd8,  8'd5,  8'd3,  8'd0};
            4'd7:  row = {8'd43,  8'd29,  8'd20,  8'd15, 8'd10, 8'd7,  8'd4,  8'd1};
            4'd8:  row = {8'd53,  8'd35,  8'd25,  8'd18, 8'd13, 8'd8,  8'd4,  8'd1};
            4'd9:  row = {8'd64,  8'd43,  8'd31,  8'd22, 8'd16, 8'd10, 8'd6,  8'd1};
            4'd10: row = {8'd76,  8'd51,  8'd37,  8'd27, 8'd19, 8'd12, 8'd7,  8'd2};
            4'd11: row = {8'd96,  8'd64,  8'd46,  8'd34, 8'd24, 8'd16, 8'd9,  8'd2};
            4'd12: row = {8'd117, 8'd79,  8'd57,  8'd41, 8'd29, 8'd19, 8'd11, 8'd3};
            4'd13: row = {8'd143, 8'd96,  8'd69,  8'd50, 8'd36, 8'd24, 8'd13, 8'd4};
            4'd14: row = {8'd175, 8'd118, 8'd85,  8'd62, 8'd44, 8'd29, 8'd16, 8'd4};
            default: row = {8'd214, 8'd144, 8'd104, 8'd76, 8'd54, 8'd36, 8'd20, 8'd6};
        endcase
        mag  = int'(row[code[2:0]*8 +: 8]);
        pred = pred + 32'(code[3] ? -mag : mag);
        case (code[2:0])
            3'd0, 3'd1: nxt = int'(step_idx) - 1;
            3'd2, 3'd3: nxt = int'(step_idx);
            3'd4:       nxt = int'(step_idx) + 1;
            3'd5, 3'd6: nxt = int'(step_idx) + 2;
            default:    nxt = int'(step_idx) + 3;
        endcase
        if (nxt < 0)
            nxt = 0;
        if (nxt > 15)
            nxt = 15;
        step_idx = 4'(nxt);
        scaled = longint'($signed(pred)) * 128;
        if (scaled < -32768)
            return 16'h8000;
        if (scaled > 32767)
            return 16'h7fff;
        return scaled[15:0];
    endfunction

    // parse one rom byte and queue the results it is due to produce
    task automatic decode_rom_byte(input logic [7:0] b, input logic lead);
        result_t    res [0:1];
        int         n;
        logic       fixed_blk;
        logic [1:0] top;
        logic [3:0] nib [0:1];
        n = 0;
        if (lead)
        begin
            parse_stage  = STAGE_OPCODE;
            bytes_left   = 0;
            step_idx     = 4'd0;
            pred         = 32'd0;
            seen_nonzero = 1'b0;
            nib_dropped  = 1'b0;
            blocks_done  = 0;
            phrase_over  = 1'b0;
        end
        if (!phrase_over)
        begin
            live_words++;
            top = b[7:6];
            case (parse_stage)
                STAGE_OPCODE:
                begin
                    if (blocks_done >= GUARD_BLOCKS ||
                        (b == 8'h00 && (!cfg_model.parse_mode || seen_nonzero)))
                    begin
                        phrase_over = 1'b1;
                        res[n++] = make_result(KIND_END, '0, '0, '0, 1'b0);
                    end
                    else
                    begin
                        if (b != 8'h00)
                            seen_nonzero = 1'b1;
                        blocks_done++;
                        fixed_blk = cfg_model.parse_mode ? (top == 2'b01) : b[6];
                        if (fixed_blk || top == 2'b10)
                        begin
                            if (cfg_model.fresh_predictor_per_block)
                            begin
                                pred     = 32'd0;
                                step_idx = 4'd0;
                            end
                            res[n++] = make_result(KIND_BLOCK, '0, '0,
                                cfg_model.honor_rate_markers ? b[5:0] : 6'd0,
                                cfg_model.honor_rate_markers);
                            if (fixed_blk)
                            begin
                                bytes_left  = FIXED_BYTES;
                                parse_stage = STAGE_DATA;
                            end
                            else
                                parse_stage = STAGE_COUNT;
                        end
                        else if (top == 2'b00)
                        begin
                            if (cfg_model.silence_clears_predictor)
                            begin
                                pred     = 32'd0;
                                step_idx = 4'd0;
                            end
                            res[n++] = make_result(KIND_SILENCE, '0,
                                15'(256 * (b[5:0] + 1)), '0, 1'b0);
                        end
                        else
                            res[n++] = make_result(KIND_REPEAT, '0, 15'(b[2:0] + 1), '0, 1'b0);
                    end
                end
                STAGE_COUNT:
                begin
                    bytes_left  = cfg_model.count_in_bytes ? int'(b) + 1 : (int'(b) + 1) >> 1;
                    parse_stage = (bytes_left != 0) ? STAGE_DATA : STAGE_OPCODE;
                end
                default:
                begin
                    nib[0] = cfg_model.low_nibble_first ? b[3:0] : b[7:4];
                    nib[1] = cfg_model.low_nibble_first ? b[7:4] : b[3:0];
                    for (int i = 0; i < 2; i++)
                    begin
                        if (cfg_model.drop_first_nibble && !nib_dropped)
                            nib_dropped = 1'b1;
                        else
                            res[n++] = make_result(KIND_SAMPLE, decode_nibble(nib[i]),
                                                   '0, '0, 1'b0);
                    end
                    if (bytes_left > 0)
                        bytes_left--;
                    if (bytes_left == 0)
                        parse_stage = STAGE_OPCODE;
                end
            endcase
        end
        for (int i = 0; i < n; i++)
        begin
            res[i].last = (i == n - 1);
            due_results = {due_results, res[i]};
        end
    endtask

    // offer one word; valid stays high after acceptance until the next call
    task automatic send_rom_byte(input logic [7:0] b, input logic lead);
        @(negedge clk);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_valid     = 1'b1;
        rom_byte     = b;
        phrase_begin = lead;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        decode_rom_byte(b, lead);
        words_in++;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid     = 1'b0;
        phrase_begin = 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic v);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        case (idx)
            CFG_PARSE_MODE:     cfg_model.parse_mode                = v;
            CFG_LOW_NIBBLE:     cfg_model.low_nibble_first          = v;
            CFG_DROP_FIRST:     cfg_model.drop_first_nibble         = v;
            CFG_FRESH_PRED:     cfg_model.fresh_predictor_per_block = v;
            CFG_HONOR_RATE:     cfg_model.honor_rate_markers        = v;
            CFG_SILENCE_CLEARS: cfg_model.silence_clears_predictor  = v;
            CFG_COUNT_IN_BYTES: cfg_model.count_in_bytes            = v;
            default: ;
        endcase
    endtask

    task automatic apply_config(input cfg_t c);
        settle();
        write_reg(CFG_PARSE_MODE,     c.parse_mode);
        write_reg(CFG_LOW_NIBBLE,     c.low_nibble_first);
        write_reg(CFG_DROP_FIRST,     c.drop_first_nibble);
        write_reg(CFG_FRESH_PRED,     c.fresh_predictor_per_block);
        write_reg(CFG_HONOR_RATE,     c.honor_rate_markers);
        write_reg(CFG_SILENCE_CLEARS, c.silence_clears_predictor);
        write_reg(CFG_COUNT_IN_BYTES, c.count_in_bytes);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // mostly well-formed phrase with random content, now and then cut short
    task automatic send_random_phrase();
        int         nblocks;
        int         cut;
        int         sel;
        int         count;
        int         nbytes;
        logic [7:0] op;
        logic       lead;
        logic       broken;
        lead    = 1'b1;
        broken  = 1'b0;
        nblocks = $urandom_range(1, 6);
        cut     = ($urandom_range(0, 7) == 0) ? $urandom_range(0, nblocks - 1) : -1;
        phrases_sent++;
        for (int k = 0; k < nblocks && !broken; k++)
        begin
            sel    = $urandom_range(0, 19);
            nbytes = 0;
            if (sel < 5)
                op = {2'b00, 6'($urandom_range((cfg_model.parse_mode && k == 0) ? 0 : 1, 63))};
            else if (sel < 8 && cfg_model.parse_mode)
                op = {2'b11, 6'($urandom_range(0, 63))};
            else if (sel == 8)
                op = cfg_model.parse_mode ? {2'b01, 6'($urandom_range(0, 63))}
                                          : {1'($urandom_range(0, 1)), 1'b1,
                                             6'($urandom_range(0, 63))};
            else
                op = {2'b10, 6'($urandom_range(0, 63))};
            send_rom_byte(op, lead);
            lead = 1'b0;
            if (op[7:6] == 2'b10)
            begin
                count = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 9);
                send_rom_byte(8'(count), 1'b0);
                nbytes = cfg_model.count_in_bytes ? count + 1 : (count + 1) >> 1;
            end
            else if (cfg_model.parse_mode ? (op[7:6] == 2'b01) : op[6])
                nbytes = FIXED_BYTES;
            if (k == cut)
            begin
                nbytes = $urandom_range(0, nbytes);
                broken = 1'b1;
            end
            repeat (nbytes) send_rom_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        if (!broken)
        begin
            send_rom_byte(8'h00, 1'b0);
            repeat ($urandom_range(0, 2)) send_rom_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic test_archive_opcodes();
        apply_config('0);
        send_rom_byte(8'h3f, 1'b1);
        send_rom_byte(8'h80, 1'b0);
        send_rom_byte(8'h00, 1'b0);
        send_rom_byte(8'ha5, 1'b0);
        send_rom_byte(8'h03, 1'b0);
        send_rom_byte(8'hff, 1'b0);
        send_rom_byte(8'h00, 1'b0);
        send_rom_byte(8'hc0, 1'b0);
        send_rom_byte(8'h7f, 1'b0);
        send_rom_byte(8'h00, 1'b1);
        send_rom_byte(8'h5a, 1'b0);
    endtask

    task automatic test_standard_mode();
        cfg_t c;
        c                    = '0;
        c.parse_mode         = 1'b1;
        c.low_nibble_first   = 1'b1;
        c.honor_rate_markers = 1'b1;
        c.count_in_bytes     = 1'b1;
        apply_config(c);
        send_rom_byte(8'h00, 1'b1);
        send_rom_byte(8'hc0, 1'b0);
        send_rom_byte(8'hff, 1'b0);
        send_rom_byte(8'h7f, 1'b0);
        send_rom_byte(8'h0f, 1'b0);
        send_rom_byte(8'hf0, 1'b0);
        send_rom_byte(8'hbf, 1'b1);
        send_rom_byte(8'h00, 1'b0);
        send_rom_byte(8'h88, 1'b0);
        send_rom_byte(8'h00, 1'b0);
    endtask

    task automatic test_nibble_options();
        cfg_t c;
        c                           = '0;
        c.drop_first_nibble         = 1'b1;
        c.fresh_predictor_per_block = 1'b1;
        c.silence_clears_predictor  = 1'b1;
        apply_config(c);
        send_rom_byte(8'h81, 1'b1);
        send_rom_byte(8'h03, 1'b0);
        send_rom_byte(8'h77, 1'b0);
        send_rom_byte(8'h77, 1'b0);
        send_rom_byte(8'h02, 1'b0);
        send_rom_byte(8'h81, 1'b0);
        send_rom_byte(8'h01, 1'b0);
        send_rom_byte(8'h99, 1'b0);
        send_rom_byte(8'h00, 1'b0);
    endtask

    task automatic test_random_phrases();
        cfg_t c;
        int   target;
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 0)
                c = '0;
            else if (ph == 1)
                c = '1;
            else
                c = cfg_t'($urandom_range(0, 127));
            apply_config(c);
            calm   = (ph == 3);
            target = live_words + 190;
            while (live_words < target)
            begin
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 6))
                        send_rom_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                else
                    send_random_phrase();
            end
        end
        calm = 1'b0;
    endtask

    // a phrase longer than the block limit, run with both sides flat out
    task automatic test_block_guard();
        cfg_t c;
        c            = cfg_t'($urandom_range(0, 127));
        c.parse_mode = 1'b1;
        apply_config(c);
        calm = 1'b1;
        send_rom_byte(8'h01, 1'b1);
        for (int k = 1; k < GUARD_BLOCKS; k++)
            send_rom_byte($urandom_range(0, 1) ? {2'b00, 6'($urandom_range(1, 63))}
                                               : {2'b11, 6'($urandom_range(0, 63))}, 1'b0);
        send_rom_byte(8'h05, 1'b0);
        send_rom_byte(8'hc3, 1'b0);
        send_rom_byte(8'h00, 1'b1);
    endtask

    always @(negedge clk)
    begin
        if (calm)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 8);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (due_results.size() == 0)
                report_mismatch($sformatf("unexpected word kind %0d pcm %0d run %0d",
                                          kind, pcm_sample, run_length));
            else
            begin
                want = due_results.pop_front();
                if (kind !== want.kind || pcm_sample !== want.pcm ||
                    run_length !== want.run || rate_divider !== want.div ||
                    rate_from_marker !== want.from_marker || last_of_item !== want.last)
                    report_mismatch($sformatf({"word %0d got kind %0d pcm %0d run %0d ",
                        "div %0d mark %0b last %0b, want kind %0d pcm %0d run %0d ",
                        "div %0d mark %0b last %0b"}, results_seen,
                        kind, pcm_sample, run_length, rate_divider, rate_from_marker,
                        last_of_item, want.kind, $signed(want.pcm), want.run, want.div,
                        want.from_marker, want.last));
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_archive_opcodes();
        test_standard_mode();
        test_nibble_options();
        test_random_phrases();
        test_block_guard();
        settle();
        repeat (20) @(posedge clk);
        $display("sent %0d rom words (%0d parsed) in %0d random phrases plus directed cases",
                 words_in, live_words, phrases_sent);
        $display("checked %0d result words over 10 register settings, %0d mismatches",
                 results_seen, mismatches);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
